[src/bfd_pkg.sv]
package bfd_pkg;

	localparam int BYTE_W    = 8;
	localparam int GAIN_W    = 24;
	localparam int RAW_W     = 24;
	localparam int PART_W    = 16;
	localparam int PROD_W    = 48;
	localparam int SAMPLE_W  = 32;
	localparam int CHAN_W    = 5;
	localparam int TSUM_W    = 11;
	localparam int TABS_W    = 10;
	localparam int QUO_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam int DIGITAL_COUNT = 3;
	localparam int DIG_W         = 2;

	localparam logic [GAIN_W-1:0] EEG_GAIN_RESET = GAIN_W'(207524);
	localparam logic [GAIN_W-1:0] EMG_GAIN_RESET = GAIN_W'(897876);

	// divide by 127 on magnitudes up to 896: (x * 1033) >> 17
	localparam int DIV127_MUL   = 1033;
	localparam int DIV127_SHIFT = 17;
	localparam int DIV127_W     = 20;

	localparam int ROUND_SHIFT = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EEG_GAIN = 1'b0,
		REG_EMG_GAIN = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                     has_result;
		logic                     is_trig;
		logic [CHAN_W-1:0]        chan;
		logic signed [RAW_W-1:0]  raw;
		logic [GAIN_W-1:0]        gain;
		logic signed [TSUM_W-1:0] tsum;
	} item_t;

endpackage

[src/bfd_if.sv]
interface bfd_byte_if import bfd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface bfd_sample_if import bfd_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [CHAN_W-1:0]          channel_index;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       frame_last;

	modport source (output valid, output channel_index, output sample_value,
		output frame_last, input ready);
	modport sink (input valid, input channel_index, input sample_value,
		input frame_last, output ready);
endinterface

[src/bfd_unpack.sv]
module bfd_unpack import bfd_pkg::*; #(
	parameter int EEG_COUNT     = 16,
	parameter int EMG_COUNT     = 6,
	parameter int BATTERY_COUNT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [GAIN_W-1:0] eeg_gain,
	input  logic [GAIN_W-1:0] emg_gain,
	output item_t             item
);

	localparam int SAMPLE_CHANNELS = EEG_COUNT + EMG_COUNT;
	localparam int SAMPLE_BYTES    = 3 * SAMPLE_CHANNELS;
	localparam int FRAME_BYTES     = SAMPLE_BYTES + DIGITAL_COUNT + BATTERY_COUNT;
	localparam int POS_W           = $clog2(FRAME_BYTES);
	localparam int CHN_W           = $clog2(SAMPLE_CHANNELS + 1);

	logic [POS_W-1:0]         pos_q;
	logic [1:0]               phase_q;
	logic [CHN_W-1:0]         chan_q;
	logic [PART_W-1:0]        partial_q;
	logic signed [TSUM_W-1:0] tsum_q;

	logic                     in_samples;
	logic                     in_digital;
	logic [POS_W-1:0]         dig_off;
	logic [DIG_W-1:0]         dig_idx;
	logic signed [TSUM_W-1:0] weighted;
	logic signed [TSUM_W-1:0] tsum_next;
	logic                     frame_end;

	always_comb begin
		in_samples = pos_q < POS_W'(SAMPLE_BYTES);
		in_digital = !in_samples && (pos_q < POS_W'(SAMPLE_BYTES + DIGITAL_COUNT));
		dig_off    = pos_q - POS_W'(SAMPLE_BYTES);
		dig_idx    = dig_off[DIG_W-1:0];
		weighted   = TSUM_W'($signed(rx_byte)) <<< dig_idx;
		tsum_next  = (dig_idx == '0) ? weighted : tsum_q + weighted;
		frame_end  = pos_q == POS_W'(FRAME_BYTES - 1);

		item.has_result = (in_samples && phase_q == 2'd2)
			|| (in_digital && dig_idx == DIG_W'(DIGITAL_COUNT - 1));
		item.is_trig = !in_samples;
		item.chan    = in_samples ? CHAN_W'(chan_q) : CHAN_W'(SAMPLE_CHANNELS);
		item.raw     = {partial_q, rx_byte};
		item.gain    = (chan_q < CHN_W'(EEG_COUNT)) ? eeg_gain : emg_gain;
		item.tsum    = tsum_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			phase_q   <= '0;
			chan_q    <= '0;
			partial_q <= '0;
			tsum_q    <= '0;
		end else if (take) begin
			if (frame_end) begin
				pos_q   <= '0;
				phase_q <= '0;
				chan_q  <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
			if (in_samples) begin
				case (phase_q)
					2'd0: begin
						partial_q <= PART_W'(rx_byte);
						phase_q   <= 2'd1;
					end
					2'd1: begin
						partial_q <= {partial_q[BYTE_W-1:0], rx_byte};
						phase_q   <= 2'd2;
					end
					default: begin
						phase_q <= 2'd0;
						chan_q  <= chan_q + 1'b1;
					end
				endcase
			end
			if (in_digital) begin
				tsum_q <= tsum_next;
			end
		end
	end

endmodule

[src/biosignal_frame_deframer.sv]
// Byte stream deframer for fixed acquisition frames: three big-endian bytes per channel
// (EEG_COUNT EEG channels, then EMG_COUNT EMG channels), DIGITAL_COUNT trigger bytes and
// BATTERY_COUNT skipped bytes; frame alignment is counted from reset. One byte is taken
// per cycle unless output back-pressure stalls it. The byte completing a channel or the
// trigger yields one result, the 24x25 gain multiply sitting between stage one and stage
// two; other bytes yield nothing. Results are sample * gain / 2^16 rounded (Q24.8
// microvolts) and the trigger (weighted digital sum / 127) with frame_last set. Gains must
// be written through cfg_we/cfg_index/cfg_data while the block is idle (not enforced).
module biosignal_frame_deframer import bfd_pkg::*; #(
	parameter int EEG_COUNT     = 16,
	parameter int EMG_COUNT     = 6,
	parameter int BATTERY_COUNT = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	bfd_byte_if.sink             link,
	bfd_sample_if.source         samples
);

	logic [GAIN_W-1:0] eeg_gain_q;
	logic [GAIN_W-1:0] emg_gain_q;

	logic  take;
	item_t item;

	logic  valid_s1;
	item_t item_s1;

	logic                     valid_s2;
	logic                     is_trig_s2;
	logic [CHAN_W-1:0]        chan_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [QUO_W-1:0]  quo_s2;

	logic                       out_valid_q;
	logic [CHAN_W-1:0]          out_chan_q;
	logic signed [SAMPLE_W-1:0] out_value_q;
	logic                       out_last_q;

	logic ready_out;
	logic ready_s2;
	logic ready_s1;

	logic signed [PROD_W:0]     prod_full;
	logic [TSUM_W-1:0]          tsum_neg;
	logic [TABS_W-1:0]          tabs;
	logic [DIV127_W-1:0]        div_prod;
	logic [QUO_W-1:0]           quo_mag;
	logic signed [QUO_W-1:0]    quo;
	logic signed [PROD_W-1:0]   rounded;
	logic signed [SAMPLE_W-1:0] value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eeg_gain_q <= EEG_GAIN_RESET;
			emg_gain_q <= EMG_GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EEG_GAIN: eeg_gain_q <= cfg_data;
				REG_EMG_GAIN: emg_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ready_out  = !out_valid_q || samples.ready;
	assign ready_s2   = !valid_s2 || ready_out;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign link.ready = ready_s1;
	assign take       = link.valid && ready_s1;

	bfd_unpack #(
		.EEG_COUNT     (EEG_COUNT),
		.EMG_COUNT     (EMG_COUNT),
		.BATTERY_COUNT (BATTERY_COUNT)
	) u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx_byte  (link.rx_byte),
		.eeg_gain (eeg_gain_q),
		.emg_gain (emg_gain_q),
		.item     (item)
	);

	// stage one: assembled sample or trigger sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= take && item.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// stage two: gain product and trigger quotient
	always_comb begin
		prod_full = item_s1.raw * $signed({1'b0, item_s1.gain});
		tsum_neg  = -item_s1.tsum;
		tabs      = item_s1.tsum[TSUM_W-1] ? tsum_neg[TABS_W-1:0] : item_s1.tsum[TABS_W-1:0];
		div_prod  = DIV127_W'(tabs) * DIV127_W'(DIV127_MUL);
		quo_mag   = QUO_W'(div_prod >> DIV127_SHIFT);
		quo       = item_s1.tsum[TSUM_W-1] ? -$signed(quo_mag) : $signed(quo_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			is_trig_s2 <= item_s1.is_trig;
			chan_s2    <= item_s1.chan;
			prod_s2    <= prod_full[PROD_W-1:0];
			quo_s2     <= quo;
		end
	end

	// output register: rounding
	always_comb begin
		rounded = prod_s2 + PROD_W'(1 << (ROUND_SHIFT - 1));
		value   = is_trig_s2 ? SAMPLE_W'(quo_s2) : rounded[PROD_W-1:ROUND_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			out_chan_q  <= chan_s2;
			out_value_q <= value;
			out_last_q  <= is_trig_s2;
		end
	end

	assign samples.valid         = out_valid_q;
	assign samples.channel_index = out_chan_q;
	assign samples.sample_value  = out_value_q;
	assign samples.frame_last    = out_last_q;

endmodule

[src/bfd_checker.sv]
module bfd_checker import bfd_pkg::*; #(
	parameter int EEG_COUNT = 16,
	parameter int EMG_COUNT = 6
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [CHAN_W-1:0]          channel_index,
	input logic signed [SAMPLE_W-1:0] sample_value,
	input logic                       frame_last
);

	localparam logic [CHAN_W-1:0] TRIG_CHAN = CHAN_W'(EEG_COUNT + EMG_COUNT);

	// trigger result carries the trigger channel
	a_last_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> channel_index == TRIG_CHAN)
		else $error("frame_last on a sample channel");

	a_sample_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_last |-> channel_index != TRIG_CHAN)
		else $error("sample result on the trigger channel");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> sample_value >= -32'sd7 && sample_value <= 32'sd7)
		else $error("trigger value out of range");

	// empty output register never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel_index)
			&& $stable(sample_value) && $stable(frame_last))
		else $error("stalled result changed");

endmodule

bind biosignal_frame_deframer bfd_checker #(
	.EEG_COUNT (EEG_COUNT),
	.EMG_COUNT (EMG_COUNT)
) u_bfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (link.valid),
	.in_ready      (link.ready),
	.out_valid     (samples.valid),
	.out_ready     (samples.ready),
	.channel_index (samples.channel_index),
	.sample_value  (samples.sample_value),
	.frame_last    (samples.frame_last)
);
